// ===== src/nnwa_pkg.sv =====
// nnwa_pkg: shared widths and control types for the nearest-neighbor walk block
// no dependencies; compiled first
package nnwa_pkg;

    // fixed field widths of the channels and the configuration register
    localparam int EDGE_WEIGHT_BITS = 16;
    localparam int VERTEX_BITS      = 5;
    localparam int NODE_COUNT_BITS  = 5;

    // lower bound that node_count is clamped to
    localparam int MIN_NODES = 2;

    // control from the walk sequencer to the best-candidate unit
    typedef struct packed {
        logic clear;   // start a new scan
        logic sample;  // a read word is present this cycle
    } scan_ctl_t;

endpackage

// ===== src/nnwa_if.sv =====
// nnwa_in_if / nnwa_out_if: valid/ready channels for matrix words and path words
// depends on nnwa_pkg for the payload widths
interface nnwa_in_if import nnwa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [EDGE_WEIGHT_BITS-1:0] edge_weight;
    logic                        last_entry;

    modport source (output valid, output edge_weight, output last_entry, input ready);
    modport sink   (input valid, input edge_weight, input last_entry, output ready);
endinterface

interface nnwa_out_if import nnwa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VERTEX_BITS-1:0] vertex;
    logic                   stuck;
    logic                   path_end;

    modport source (output valid, output vertex, output stuck, output path_end, input ready);
    modport sink   (input valid, input vertex, input stuck, input path_end, output ready);
endinterface

// ===== src/nnwa_ram.sv =====
// nnwa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module nnwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/nnwa_best.sv =====
// nnwa_best: tracks the lightest edge to an unvisited vertex over one row scan
// depends on nnwa_pkg for scan_ctl_t
module nnwa_best import nnwa_pkg::*; #(
    parameter int WEIGHT_BITS = 16,
    parameter int IDX_BITS    = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scan_ctl_t              ctl,
    input  logic [IDX_BITS-1:0]    col,
    input  logic [WEIGHT_BITS-1:0] weight,
    input  logic                   col_visited,
    output logic                   found,
    output logic [IDX_BITS-1:0]    best_col
);

    logic                   found_reg, found_next;
    logic [WEIGHT_BITS-1:0] best_w_reg, best_w_next;
    logic [IDX_BITS-1:0]    best_col_reg, best_col_next;
    logic                   take;

    // strictly lighter wins, so the lower column keeps a tie
    assign take = ctl.sample && (weight != '0) && !col_visited
                  && (!found_reg || (weight < best_w_reg));

    always_comb
    begin
        priority if (ctl.clear)
        begin
            found_next    = 1'b0;
            best_w_next   = '1;
            best_col_next = '0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_w_next   = weight;
            best_col_next = col;
        end
        else
        begin
            found_next    = found_reg;
            best_w_next   = best_w_reg;
            best_col_next = best_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_w_reg   <= '1;
            best_col_reg <= '0;
        end
        else
        begin
            found_reg    <= found_next;
            best_w_reg   <= best_w_next;
            best_col_reg <= best_col_next;
        end
    end

    assign found    = found_reg;
    assign best_col = best_col_reg;

endmodule

// ===== src/nearest_neighbor_walk_adjacency.sv =====
// Greedy nearest-neighbor walk: matrix words (row-major edge weights, zero = no edge) are
// written one per cycle into a weight ram while the block is idle. The word flagged
// last_entry starts a walk from vertex 1; the input channel stays low until the last path
// word has been handed to the output register. Each step reads one row of the ram through
// its single read port, one column per cycle: a row setup, one read per column, a drain
// state for the last read word, then one emit, which waits for a free output register; the
// final step skips the scan once every vertex is on the path, and scans a full row when the
// walk gets stuck. The path words carry 1-based vertex numbers; path_end marks the last,
// stuck marks a walk that ran out of unvisited neighbors. Depends on nnwa_pkg, nnwa_if,
// nnwa_ram, nnwa_best.
module nearest_neighbor_walk_adjacency import nnwa_pkg::*; #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       node_count_we,
    input  logic [NODE_COUNT_BITS-1:0] node_count,
    nnwa_in_if.sink                    edges,
    nnwa_out_if.source                 path
);

    localparam int IDX_BITS   = $clog2(MAX_NODES);
    localparam int N_BITS     = $clog2(MAX_NODES + 1);
    localparam int DEPTH      = MAX_NODES * MAX_NODES;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int POS_BITS   = $clog2(DEPTH + 1);
    localparam logic [7:0] MAX_NODES_W = 8'(MAX_NODES);
    localparam logic [7:0] MIN_NODES_W = 8'(MIN_NODES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROW   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [NODE_COUNT_BITS-1:0] node_count_reg;
    logic [POS_BITS-1:0]        pos_reg, pos_next;
    logic [MAX_NODES-1:0]       visited_reg, visited_next;
    logic [IDX_BITS-1:0]        cur_reg, cur_next;
    logic [N_BITS-1:0]          pl_reg, pl_next;
    logic [IDX_BITS-1:0]        scan_col_reg, scan_col_next;
    logic [ADDR_BITS-1:0]       row_base_reg, row_base_next;
    logic                       rd_valid_reg;
    logic [IDX_BITS-1:0]        rd_col_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [VERTEX_BITS-1:0]     vertex_reg, vertex_next;
    logic                       stuck_reg, stuck_next;
    logic                       end_reg, end_next;

    logic [7:0]                 n_raw;
    logic [7:0]                 n_wide;
    logic [N_BITS-1:0]          n_eff;
    logic [POS_BITS-1:0]        cells;
    logic [POS_BITS-1:0]        load_pos;
    logic                       in_fire;
    logic                       last_issue;
    logic                       slot_free;
    logic                       emit_fire;
    logic [ADDR_BITS-1:0]       raddr;
    logic [WEIGHT_BITS-1:0]     rdata;
    logic                       found;
    logic [IDX_BITS-1:0]        best_col;
    scan_ctl_t                  scan_ctl;

    // node count clamped to the supported range
    assign n_raw = {{(8 - NODE_COUNT_BITS){1'b0}}, node_count_reg};
    always_comb
    begin
        priority if (n_raw < MIN_NODES_W)
        begin
            n_wide = MIN_NODES_W;
        end
        else if (n_raw > MAX_NODES_W)
        begin
            n_wide = MAX_NODES_W;
        end
        else
        begin
            n_wide = n_raw;
        end
    end
    assign n_eff = N_BITS'(n_wide);

    // load address, wrapping once the matrix is full
    assign cells    = POS_BITS'(n_eff) * POS_BITS'(n_eff);
    assign load_pos = (pos_reg >= cells) ? '0 : pos_reg;

    assign edges.ready = (state_reg == S_IDLE);
    assign in_fire     = edges.valid && edges.ready;

    // scan read address and end of row
    assign raddr      = row_base_reg + ADDR_BITS'(scan_col_reg);
    assign last_issue = (N_BITS'(scan_col_reg) == (n_eff - N_BITS'(1)));

    // output register slot
    assign slot_free = !out_valid_reg || path.ready;
    assign emit_fire = (state_reg == S_EMIT) && slot_free;

    assign scan_ctl.clear  = (state_reg == S_ROW);
    assign scan_ctl.sample = rd_valid_reg;

    // weight store
    nnwa_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_fire),
        .waddr (load_pos[ADDR_BITS-1:0]),
        .wdata (WEIGHT_BITS'(edges.edge_weight)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // lightest unvisited neighbor of the current row
    nnwa_best #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_BITS    (IDX_BITS)
    ) u_best (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .col         (rd_col_reg),
        .weight      (rdata),
        .col_visited (visited_reg[rd_col_reg]),
        .found       (found),
        .best_col    (best_col)
    );

    // walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        pl_next        = pl_reg;
        scan_col_next  = scan_col_reg;
        row_base_next  = row_base_reg;
        out_valid_next = out_valid_reg && !path.ready;
        vertex_next    = vertex_reg;
        stuck_next     = stuck_reg;
        end_next       = end_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next = load_pos + POS_BITS'(1);
                    if (edges.last_entry)
                    begin
                        pos_next     = '0;
                        cur_next     = '0;
                        visited_next = MAX_NODES'(1);
                        pl_next      = N_BITS'(1);
                        state_next   = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                row_base_next = ADDR_BITS'(cur_reg) * ADDR_BITS'(n_eff);
                scan_col_next = '0;
                state_next    = (pl_reg < n_eff) ? S_SCAN : S_EMIT;
            end
            S_SCAN:
            begin
                scan_col_next = scan_col_reg + IDX_BITS'(1);
                if (last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    vertex_next    = VERTEX_BITS'(32'(cur_reg) + 32'd1);
                    stuck_next     = !found && (pl_reg < n_eff);
                    end_next       = !found;
                    if (found)
                    begin
                        cur_next     = best_col;
                        visited_next = visited_reg | (MAX_NODES'(1) << best_col);
                        pl_next      = pl_reg + N_BITS'(1);
                        state_next   = S_ROW;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_BITS'(16);
            pos_reg        <= '0;
            visited_reg    <= '0;
            cur_reg        <= '0;
            pl_reg         <= '0;
            scan_col_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            visited_reg   <= visited_next;
            cur_reg       <= cur_next;
            pl_reg        <= pl_next;
            scan_col_reg  <= scan_col_next;
            rd_valid_reg  <= (state_reg == S_SCAN);
            out_valid_reg <= out_valid_next;
            if (node_count_we)
            begin
                node_count_reg <= node_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_base_reg <= row_base_next;
        rd_col_reg   <= scan_col_reg;
        vertex_reg   <= vertex_next;
        stuck_reg    <= stuck_next;
        end_reg      <= end_next;
    end

    assign path.valid    = out_valid_reg;
    assign path.vertex   = vertex_reg;
    assign path.stuck    = stuck_reg;
    assign path.path_end = end_reg;

`ifndef SYNTHESIS
    // the current vertex is always marked visited during a walk
    a_cur_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> visited_reg[cur_reg])
        else $error("current vertex not marked visited");

    // path length never passes the node count
    a_pl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((pl_reg <= n_eff) && (pl_reg != '0)))
        else $error("path length out of range");

    // read words only arrive while a row is being scanned
    a_rd_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ((state_reg == S_SCAN) || (state_reg == S_DRAIN)))
        else $error("read word outside a row scan");

    // the final path word returns the block to idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !found) |=> ((state_reg == S_IDLE) && path.valid && path.path_end))
        else $error("walk did not end after final word");

    // a waiting path word is never replaced
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !path.ready) |=> (out_valid_reg && $stable(vertex_reg)))
        else $error("pending path word overwritten");
`endif

endmodule
